[rtl/spa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared sizes, codes and control types of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int POOL_SLOTS = 256;
  localparam int IDX_W      = $clog2(POOL_SLOTS);
  localparam int HINT_W     = $clog2(POOL_SLOTS + 1);
  localparam int CMP_W      = (HINT_W > 9) ? HINT_W : 9;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_HIDE    = 3'd2;
  localparam logic [2:0] CMD_SHOW    = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_USED   = 2'd1;
  localparam logic [1:0] ST_HIDDEN = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_STATE = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_create;
    logic hint_at_end;
    logic slot_empty;
    logic out_free;
  } ctl_stat_t;

endpackage

[rtl/spa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer: accept a word, read the slot, then scan or finish.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  spa_pkg::ctl_stat_t stat,
  output spa_pkg::ctl_cmd_t  cmd
);
  import spa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // occupied slot during create: advance the hint and read again
        if (stat.is_create && !stat.hint_at_end && !stat.slot_empty) begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/spa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_datapath
// Slot state memory, valid bits, search hint and result register.
// ----------------------------------------------------------------------------
module spa_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [spa_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [spa_pkg::OUT_W-1:0] out_tdata,
  input  spa_pkg::ctl_cmd_t        cmd,
  output spa_pkg::ctl_stat_t       stat
);
  import spa_pkg::*;

  logic [1:0]        mem [POOL_SLOTS];
  logic              valid_r [POOL_SLOTS];
  logic [2:0]        cmd_r;
  logic [7:0]        idx_r;
  logic [HINT_W-1:0] hint_r, hint_nxt;
  logic [1:0]        rd_st_r;
  logic              rd_vld_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [IDX_W-1:0]  addr;
  logic              in_range;
  logic              hint_at_end;
  logic [1:0]        st;
  logic              wr_en;
  logic [1:0]        wr_st;
  logic              lower;
  logic              res_ok;
  logic [7:0]        res_idx;
  logic [1:0]        res_err;
  logic [1:0]        res_st;

  assign hint_at_end = (hint_r == HINT_W'(POOL_SLOTS));
  assign addr        = (cmd_r == CMD_CREATE) ? hint_r[IDX_W-1:0] : IDX_W'(idx_r);
  assign in_range    = (CMP_W'(idx_r) < CMP_W'(POOL_SLOTS));
  assign st          = (in_range && rd_vld_r) ? rd_st_r : ST_EMPTY;

  assign stat.is_create   = (cmd_r == CMD_CREATE);
  assign stat.hint_at_end = hint_at_end;
  assign stat.slot_empty  = !rd_vld_r || (rd_st_r == ST_EMPTY);
  assign stat.out_free    = !out_valid_r || out_tready;

  always_comb begin
    wr_en   = 1'b0;
    wr_st   = ST_EMPTY;
    lower   = 1'b0;
    res_ok  = 1'b0;
    res_idx = idx_r;
    res_err = ERR_STATE;
    res_st  = st;
    case (cmd_r)
      CMD_CREATE: begin
        if (hint_at_end) begin
          res_idx = 8'd0;
          res_err = ERR_FULL;
          res_st  = ST_EMPTY;
        end else begin
          wr_en   = 1'b1;
          wr_st   = ST_USED;
          res_ok  = 1'b1;
          res_idx = 8'(hint_r);
          res_err = ERR_NONE;
          res_st  = ST_USED;
        end
      end
      CMD_DESTROY: begin
        if (in_range && st == ST_USED) begin
          wr_en   = 1'b1;
          wr_st   = ST_EMPTY;
          lower   = (CMP_W'(idx_r) < CMP_W'(hint_r));
          res_ok  = 1'b1;
          res_err = ERR_NONE;
          res_st  = ST_EMPTY;
        end
      end
      CMD_HIDE: begin
        if (in_range && st == ST_USED) begin
          wr_en   = 1'b1;
          wr_st   = ST_HIDDEN;
          res_ok  = 1'b1;
          res_err = ERR_NONE;
          res_st  = ST_HIDDEN;
        end
      end
      CMD_SHOW: begin
        if (in_range && st == ST_HIDDEN) begin
          wr_en   = 1'b1;
          wr_st   = ST_USED;
          res_ok  = 1'b1;
          res_err = ERR_NONE;
          res_st  = ST_USED;
        end
      end
      CMD_QUERY: begin
        if (in_range && st == ST_USED) begin
          res_ok  = 1'b1;
          res_err = ERR_NONE;
        end
      end
      default: begin
        res_err = ERR_NONE;
      end
    endcase
  end

  always_comb begin
    hint_nxt = hint_r;
    if (cmd.step) begin
      hint_nxt = hint_r + HINT_W'(1);
    end else if (cmd.finish && lower) begin
      hint_nxt = HINT_W'(idx_r);
    end
  end

  // slot states: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem[addr] <= wr_st;
    end
    if (cmd.rd_en) begin
      rd_st_r  <= mem[addr];
      rd_vld_r <= valid_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.finish && wr_en) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_tdata[2:0];
      idx_r <= in_tdata[10:3];
    end
    if (cmd.finish) begin
      out_data_r <= {3'b000, res_st, res_err, res_idx, res_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hint_r <= hint_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/slot_pool_allocator.sv]
`timescale 1ns / 1ps
// Sequence: a word is accepted, its slot is read, and the result is registered
//   at finish; create reads again for every occupied slot it steps over from
//   the search hint. Words pass the accept, read and evaluate steps of the
//   controller, and a new word is taken only after the last one has finished.
// Reset: synchronous, active low; all slots read empty at once (valid bits
//   clear), hint goes to zero, output register empties.
// ----------------------------------------------------------------------------
// slot_pool_allocator
// First-fit slot pool with a search hint: create, destroy, hide, show, query.
// ----------------------------------------------------------------------------
module slot_pool_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  // input word
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [spa_pkg::IN_W-1:0]  in_tdata,   // [2:0] command, [10:3] slot_index
  // result word
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [spa_pkg::OUT_W-1:0] out_tdata   // [0] ok, [8:1] result_index,
                                                // [10:9] error_code, [12:11] slot_state
);
  import spa_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Controller: take a word only when idle, walk the create scan one slot
  // per read/evaluate pair, and hold the finish until the output register
  // frees up.
  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: slot memory with per-slot valid bits, the hint register,
  // the command decode and the output register.
  spa_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
